[hdl/nir_pkg.sv]
// Shared types and timing constants for the NEC infrared pulse decoder.
`timescale 1ns / 1ps
package nir_pkg;

  typedef struct packed {
    logic        level;
    logic [15:0] duration_us;
  } pulse_t;

  typedef struct packed {
    logic        event_kind;
    logic [31:0] frame_bits;
  } event_t;

  // Classified pulse: level plus one flag per timing window
  typedef struct packed {
    logic level;
    logic win_leader;
    logic win_lspace;
    logic win_rspace;
    logic win_short;
    logic win_long;
  } cls_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  localparam logic EV_FRAME  = 1'b0;
  localparam logic EV_REPEAT = 1'b1;

  // Window bounds in us, both exclusive
  localparam logic [15:0] LEADER_LO = 16'(9000 - 900);
  localparam logic [15:0] LEADER_HI = 16'(9000 + 900);
  localparam logic [15:0] LSPACE_LO = 16'(4500 - 450);
  localparam logic [15:0] LSPACE_HI = 16'(4500 + 450);
  localparam logic [15:0] RSPACE_LO = 16'(2500 - 250);
  localparam logic [15:0] RSPACE_HI = 16'(2500 + 250);
  localparam logic [15:0] SHORT_LO  = 16'(560 - 100);
  localparam logic [15:0] SHORT_HI  = 16'(560 + 100);
  localparam logic [15:0] LONG_LO   = 16'(1690 - 200);
  localparam logic [15:0] LONG_HI   = 16'(1690 + 200);

  typedef enum logic [5:0] {
    ST_LEADER_MARK  = 6'b000001,
    ST_LEADER_SPACE = 6'b000010,
    ST_REPEAT_STOP  = 6'b000100,
    ST_BIT_MARK     = 6'b001000,
    ST_BIT_SPACE    = 6'b010000,
    ST_STOP_MARK    = 6'b100000
  } phase_t;

endpackage

[hdl/nec_ir_pulse_decoder.sv]
// Top level of the NEC infrared pulse decoder.
//
//   channel   direction  payload     beat
//   in        input      pulse_t     one measured pulse (level, duration_us)
//   out       output     event_t     one frame or repeat event
//
// One pulse beat per cycle while the queue is not full; the stop mark beat is
// written into the queue, then the framer puts its result into the result register.
// The front end classifies in the accepting cycle; the framer takes one
// queued pulse per cycle whenever the result register is free or draining.
// Synchronous reset clears the queue, the framer state and out_valid.
// A stalled output fills the two-entry queue, after which in_ready drops.
`timescale 1ns / 1ps
module nec_ir_pulse_decoder #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  nir_pkg::pulse_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output nir_pkg::event_t out_data
);
  import nir_pkg::*;

  qstat_t q_stat;
  cls_t   push_data;
  cls_t   head;
  logic   push;
  logic   pop;

  nir_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  nir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  nir_framer #(
    .FRAME_BITS (FRAME_BITS)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  a_repeat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_kind == EV_REPEAT) |-> out_data.frame_bits == '0)
    else $error("repeat event carries data bits");

  a_frame_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_kind == EV_FRAME)
      |-> (64'(out_data.frame_bits) >> FRAME_BITS) == 64'd0)
    else $error("frame has bits above the frame length");

  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !pop |=> q_stat.count == $past(q_stat.count) + 1'b1)
    else $error("queue count lost an accepted beat");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !in_ready)
    else $error("input accepted into a full queue");
`endif

endmodule

[hdl/nir_front.sv]
// Front end: accepts pulse beats and classifies the duration into timing windows.
`timescale 1ns / 1ps
module nir_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  nir_pkg::pulse_t in_data,
  input  nir_pkg::qstat_t q_stat,
  output logic            push,
  output nir_pkg::cls_t   push_data
);
  import nir_pkg::*;

  logic [15:0] t;

  assign t        = in_data.duration_us;
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_data.level      = in_data.level;
    push_data.win_leader = (t > LEADER_LO) && (t < LEADER_HI);
    push_data.win_lspace = (t > LSPACE_LO) && (t < LSPACE_HI);
    push_data.win_rspace = (t > RSPACE_LO) && (t < RSPACE_HI);
    push_data.win_short  = (t > SHORT_LO)  && (t < SHORT_HI);
    push_data.win_long   = (t > LONG_LO)   && (t < LONG_HI);
  end

endmodule

[hdl/nir_queue.sv]
// Short FIFO of classified pulses between front end and framer.
`timescale 1ns / 1ps
module nir_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  nir_pkg::cls_t   push_data,
  input  logic            pop,
  output nir_pkg::cls_t   head,
  output nir_pkg::qstat_t stat
);
  import nir_pkg::*;

  localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

  cls_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == DEPTH_CNT);
  assign stat.empty = (count == '0);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/nir_framer.sv]
// Back end: NEC framing state machine, bit collection and result register.
`timescale 1ns / 1ps
module nir_framer #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  nir_pkg::cls_t   head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output nir_pkg::event_t out_data
);
  import nir_pkg::*;

  localparam logic [5:0] FRAME_LIMIT = 6'(FRAME_BITS);

  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] shift_word;
  logic [31:0] shift_word_next;
  logic [5:0]  bit_count;
  logic [5:0]  bit_count_next;
  logic        ok;
  logic        emit;
  event_t      ev;

  // result slot free now or being drained this cycle
  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    phase_next      = phase;
    shift_word_next = shift_word;
    bit_count_next  = bit_count;
    ok              = 1'b0;
    emit            = 1'b0;
    ev.event_kind   = EV_FRAME;
    ev.frame_bits   = shift_word;
    case (phase)
      ST_LEADER_MARK: begin
        if (head.level && head.win_leader) begin
          phase_next      = ST_LEADER_SPACE;
          shift_word_next = '0;
          bit_count_next  = '0;
          ok              = 1'b1;
        end
      end
      ST_LEADER_SPACE: begin
        if (!head.level) begin
          if (head.win_lspace) begin
            phase_next = ST_BIT_MARK;
            ok         = 1'b1;
          end else if (head.win_rspace) begin
            phase_next = ST_REPEAT_STOP;
            ok         = 1'b1;
          end
        end
      end
      ST_REPEAT_STOP: begin
        if (head.level && head.win_short) begin
          phase_next    = ST_LEADER_MARK;
          emit          = 1'b1;
          ev.event_kind = EV_REPEAT;
          ev.frame_bits = '0;
          ok            = 1'b1;
        end
      end
      ST_BIT_MARK: begin
        if (head.level && head.win_short) begin
          phase_next = ST_BIT_SPACE;
          ok         = 1'b1;
        end
      end
      ST_BIT_SPACE: begin
        if (!head.level && (head.win_short || head.win_long)) begin
          ok = 1'b1;
          if (head.win_long && !head.win_short) begin
            shift_word_next[bit_count[4:0]] = 1'b1;
          end
          bit_count_next = bit_count + 6'd1;
          phase_next     = (bit_count_next >= FRAME_LIMIT) ? ST_STOP_MARK : ST_BIT_MARK;
        end
      end
      ST_STOP_MARK: begin
        if (head.level && head.win_short) begin
          phase_next = ST_LEADER_MARK;
          emit       = 1'b1;
          ok         = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!ok) begin
      phase_next = ST_LEADER_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ST_LEADER_MARK;
      shift_word <= '0;
      bit_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        shift_word <= shift_word_next;
        bit_count  <= bit_count_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= ev;
    end
  end

endmodule

[tb/nir_event_monitor.sv]
// Event monitor for the NEC IR pulse decoder: predicts frame/repeat events and checks output beats.
`timescale 1ns / 1ps
module nir_event_monitor #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  nir_pkg::pulse_t in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  nir_pkg::event_t out_data,
  output int              fail_count,
  output int              pending,
  output int              frames_due,
  output int              repeats_due
);
  import nir_pkg::*;

  phase_t      phase;
  logic [31:0] shift_word;
  logic [5:0]  bit_count;
  event_t      due_events[$];

  function automatic logic in_win(input logic [15:0] t, input logic [15:0] lo,
                                  input logic [15:0] hi);
    return (t > lo) && (t < hi);
  endfunction

  // Advance the framer model by one pulse; queue any event it completes
  task automatic decode_pulse(input pulse_t p);
    logic        ok;
    logic        one;
    logic        mark;
    logic [15:0] t;
    ok   = 1'b0;
    one  = 1'b0;
    mark = p.level;
    t    = p.duration_us;
    case (phase)
      ST_LEADER_MARK: begin
        if (mark && in_win(t, LEADER_LO, LEADER_HI)) begin
          phase      = ST_LEADER_SPACE;
          shift_word = '0;
          bit_count  = '0;
          ok         = 1'b1;
        end
      end
      ST_LEADER_SPACE: begin
        if (!mark) begin
          // long space window has priority; the two are disjoint anyway
          if (in_win(t, LSPACE_LO, LSPACE_HI)) begin
            phase = ST_BIT_MARK;
            ok    = 1'b1;
          end else if (in_win(t, RSPACE_LO, RSPACE_HI)) begin
            phase = ST_REPEAT_STOP;
            ok    = 1'b1;
          end
        end
      end
      ST_REPEAT_STOP: begin
        if (mark && in_win(t, SHORT_LO, SHORT_HI)) begin
          phase = ST_LEADER_MARK;
          due_events.push_back('{event_kind: EV_REPEAT, frame_bits: '0});
          repeats_due++;
          ok = 1'b1;
        end
      end
      ST_BIT_MARK: begin
        if (mark && in_win(t, SHORT_LO, SHORT_HI)) begin
          phase = ST_BIT_SPACE;
          ok    = 1'b1;
        end
      end
      ST_STOP_MARK: begin
        if (mark && in_win(t, SHORT_LO, SHORT_HI)) begin
          phase = ST_LEADER_MARK;
          due_events.push_back('{event_kind: EV_FRAME, frame_bits: shift_word});
          frames_due++;
          ok = 1'b1;
        end
      end
      ST_BIT_SPACE: begin
        if (!mark) begin
          if (in_win(t, SHORT_LO, SHORT_HI)) begin
            ok = 1'b1;
          end else if (in_win(t, LONG_LO, LONG_HI)) begin
            ok  = 1'b1;
            one = 1'b1;
          end
          if (ok) begin
            if (one) shift_word[bit_count[4:0]] = 1'b1;
            bit_count = bit_count + 6'd1;
            phase = (bit_count >= FRAME_BITS) ? ST_STOP_MARK : ST_BIT_MARK;
          end
        end
      end
      default: ;
    endcase
    if (!ok) phase = ST_LEADER_MARK;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase       = ST_LEADER_MARK;
      shift_word  = '0;
      bit_count   = '0;
      fail_count  = 0;
      frames_due  = 0;
      repeats_due = 0;
      due_events.delete();
    end else begin
      // output first: an event can never belong to the pulse taken this edge
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          $error("unexpected event beat: event_kind %0d frame_bits %h",
                 out_data.event_kind, out_data.frame_bits);
          fail_count++;
        end else begin
          event_t want;
          want = due_events.pop_front();
          if (out_data.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind,
                   out_data.event_kind);
            fail_count++;
          end
          if (out_data.frame_bits !== want.frame_bits) begin
            $error("frame_bits: expected %h, got %h", want.frame_bits,
                   out_data.frame_bits);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) decode_pulse(in_data);
    end
    pending = due_events.size();
  end

endmodule

[tb/testbench.sv]
// Testbench top for the NEC IR pulse decoder: clock, reset, pulse stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import nir_pkg::*;

  localparam int unsigned FRAME_BITS  = 32;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          ITEM_TARGET = 1300;

  typedef enum int {
    FLAW_NONE,
    FLAW_PULSE,
    FLAW_LONG,
    FLAW_SHORT
  } flaw_t;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  pulse_t in_data   = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  event_t out_data;

  int fail_count;
  int pending;
  int frames_due;
  int repeats_due;

  int cycles     = 0;
  int item_count = 0;
  int burst_left = 0;
  bit tx_idle    = 1'b1;
  int rx_cycle   = 0;
  int rx_mode    = 0;
  int rx_hold    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nec_ir_pulse_decoder #(.FRAME_BITS(FRAME_BITS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  nir_event_monitor #(.FRAME_BITS(FRAME_BITS)) u_event_mon (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .frames_due (frames_due),
    .repeats_due(repeats_due)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: always ready, coin-flip ready, or long alternating stalls
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold == 0) begin
          out_ready = ~out_ready;
          rx_hold   = $urandom_range(1, 20);
        end else begin
          rx_hold--;
        end
      end
    endcase
  end

  function automatic logic [15:0] in_window(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 7))
      0:       return 16'(lo + 1);
      1:       return 16'(hi - 1);
      default: return 16'($urandom_range(lo + 1, hi - 1));
    endcase
  endfunction

  function automatic logic [15:0] off_window(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 2))
      0:       return lo;
      1:       return hi;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_pulse(input logic lvl, input logic [15:0] dur);
    int gap;
    gap = 0;
    if (item_count % 150 == 0) tx_idle = $urandom_range(0, 2) != 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (tx_idle) gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{level: lvl, duration_us: dur};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    item_count++;
  endtask

  task automatic send_seq(ref pulse_t seq[$]);
    foreach (seq[i]) send_pulse(seq[i].level, seq[i].duration_us);
  endtask

  // Spoil one pulse of a sequence: flip its level or push it off its window
  task automatic spoil(ref pulse_t seq[$]);
    int k;
    k = $urandom_range(0, seq.size() - 1);
    if ($urandom_range(0, 1)) seq[k].level = ~seq[k].level;
    else seq[k].duration_us = off_window(SHORT_LO, LONG_HI);
  endtask

  task automatic send_frame(input logic [31:0] word, input flaw_t flaw);
    pulse_t seq[$];
    int     nbits;
    nbits = FRAME_BITS;
    if (flaw == FLAW_LONG)  nbits++;
    if (flaw == FLAW_SHORT) nbits--;
    seq.push_back('{1'b1, in_window(LEADER_LO, LEADER_HI)});
    seq.push_back('{1'b0, in_window(LSPACE_LO, LSPACE_HI)});
    for (int i = 0; i < nbits; i++) begin
      seq.push_back('{1'b1, in_window(SHORT_LO, SHORT_HI)});
      if (word[i % 32]) seq.push_back('{1'b0, in_window(LONG_LO, LONG_HI)});
      else seq.push_back('{1'b0, in_window(SHORT_LO, SHORT_HI)});
    end
    seq.push_back('{1'b1, in_window(SHORT_LO, SHORT_HI)});
    if (flaw == FLAW_PULSE) spoil(seq);
    send_seq(seq);
  endtask

  task automatic send_repeat(input flaw_t flaw);
    pulse_t seq[$];
    seq.push_back('{1'b1, in_window(LEADER_LO, LEADER_HI)});
    seq.push_back('{1'b0, in_window(RSPACE_LO, RSPACE_HI)});
    seq.push_back('{1'b1, in_window(SHORT_LO, SHORT_HI)});
    if (flaw == FLAW_PULSE) spoil(seq);
    send_seq(seq);
  endtask

  initial begin
    int pick;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: window edges, level errors, repeat codes, error not taken as leader
    send_pulse(1'b1, 16'd0);
    send_pulse(1'b0, 16'd65535);
    send_pulse(1'b1, LEADER_LO);
    send_pulse(1'b1, LEADER_HI);
    send_pulse(1'b1, LEADER_LO + 16'd1);
    send_pulse(1'b0, RSPACE_LO + 16'd1);
    send_pulse(1'b1, SHORT_LO + 16'd1);
    send_pulse(1'b1, LEADER_HI - 16'd1);
    send_pulse(1'b0, RSPACE_HI - 16'd1);
    send_pulse(1'b1, SHORT_HI - 16'd1);
    send_pulse(1'b1, 16'd9000);
    send_pulse(1'b0, RSPACE_LO);
    send_pulse(1'b1, 16'd9000);
    send_pulse(1'b1, 16'd9000);
    send_pulse(1'b0, 16'd4500);
    send_pulse(1'b1, 16'd9000);
    send_pulse(1'b0, LSPACE_LO + 16'd1);
    send_pulse(1'b1, SHORT_LO);
    send_pulse(1'b1, 16'd9000);
    send_pulse(1'b0, LSPACE_HI - 16'd1);
    send_pulse(1'b1, 16'd560);
    send_pulse(1'b0, LONG_LO + 16'd1);
    send_pulse(1'b1, 16'd560);
    send_pulse(1'b0, LONG_HI - 16'd1);
    send_pulse(1'b1, 16'd560);
    send_pulse(1'b0, SHORT_HI);

    // hold off until the decoder has drained
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);

    send_frame(32'h0000_0000, FLAW_NONE);
    send_frame(32'hFFFF_FFFF, FLAW_NONE);

    while (item_count < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_frame($urandom, FLAW_NONE);
      end else if (pick < 35) begin
        case ($urandom_range(0, 2))
          0:       send_frame($urandom, FLAW_PULSE);
          1:       send_frame($urandom, FLAW_LONG);
          default: send_frame($urandom, FLAW_SHORT);
        endcase
      end else if (pick < 80) begin
        send_repeat(($urandom_range(0, 5) == 0) ? FLAW_PULSE : FLAW_NONE);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) begin
            send_pulse(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
          end else begin
            send_pulse(1'($urandom_range(0, 1)), off_window(SHORT_LO, LEADER_HI));
          end
        end
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(posedge clk);

    $display("Decoded %0d pulses: %0d frames and %0d repeat codes checked, with",
             item_count, frames_due, repeats_due);
    $display("  window edges, level errors, spoilt, short and overlong frames mixed in.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
